@@ design/bm3_pkg.sv @@
package bm3_pkg;

   // image limits and derived widths
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int AREA_W     = 2 * SIZE_W;
   localparam int PIX_W      = 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // queue depths
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = Q_PTR_W + 1;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W  = OUT_PTR_W + 1;

   // input command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 3'd0,
      CSR_IMAGE_HEIGHT    = 3'd1,
      CSR_ERODE_MODE      = 3'd2,
      CSR_EIGHT_CONNECTED = 3'd3,
      CSR_BLACK_LEVEL     = 3'd4,
      CSR_WHITE_LEVEL     = 3'd5
   } csr_index_type;

   // effective configuration, sizes already clamped
   typedef struct packed {
      logic [SIZE_W-1:0] w;
      logic [COL_W-1:0]  w_m1;
      logic [ROW_W-1:0]  h_m1;
      logic              erode;
      logic              eight;
      logic [PIX_W-1:0]  black;
      logic [PIX_W-1:0]  white;
   } cfg_type;

   // classified item from front to back
   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic [COL_W-1:0] col;
      logic             emit;
      logic [COL_W-1:0] ecol;
      logic [ROW_W-1:0] erow;
      logic             last;
      logic             at_top;
      logic             at_bottom;
      logic             at_left;
      logic             at_right;
   } fe_item_type;

   // result item
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
   } out_item_type;

   // back end occupancy
   typedef struct packed {
      logic [OUT_CNT_W-1:0] out_count;
      logic                 a_valid;
   } bk_status_type;

endpackage

@@ design/bm3_ram.sv @@
module bm3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/bm3_front.sv @@
module bm3_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  bm3_pkg::cfg_type             cfg,
   input  logic [bm3_pkg::AREA_W-1:0]   wh,
   input  logic                         req_push,
   input  logic                         req_command,
   input  logic [bm3_pkg::PIX_W-1:0]    req_pixel_in,
   output logic                         req_full,
   output logic                         q_push,
   output bm3_pkg::fe_item_type         q_item,
   input  logic                         q_full
);
   import bm3_pkg::*;

   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  emit_col_ff, emit_col_in;
   logic [ROW_W-1:0]  emit_row_ff, emit_row_in;
   logic [SIZE_W-1:0] fill_ff, fill_in;
   logic [AREA_W-1:0] done_ff, done_in;
   logic              accept, drain, drain_ok, take, emit, last;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign drain    = (req_command == CMD_DRAIN);

   // drain counts only once the whole frame of the next output is in
   assign drain_ok = (fill_ff != '0) &&
                     ((AREA_W'(fill_ff) + done_ff) >= wh);
   assign take     = !drain || drain_ok;
   assign emit     = fill_ff > cfg.w;
   assign last     = (emit_row_ff == cfg.h_m1) && (emit_col_ff == cfg.w_m1);

   // classified item
   always_comb begin
      q_item.pix       = drain ? '0 : req_pixel_in;
      q_item.col       = in_col_ff;
      q_item.emit      = emit;
      q_item.ecol      = emit_col_ff;
      q_item.erow      = emit_row_ff;
      q_item.last      = last;
      q_item.at_top    = (emit_row_ff == '0);
      q_item.at_bottom = (emit_row_ff == cfg.h_m1);
      q_item.at_left   = (emit_col_ff == '0);
      q_item.at_right  = (emit_col_ff == cfg.w_m1);
   end
   assign q_push = accept && take;

   // position and fill tracking
   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      emit_col_in = emit_col_ff;
      emit_row_in = emit_row_ff;
      fill_in     = fill_ff;
      done_in     = done_ff;
      if (clear) begin
         in_col_in   = '0;
         in_row_in   = '0;
         emit_col_in = '0;
         emit_row_in = '0;
         fill_in     = '0;
         done_in     = '0;
      end else if (q_push) begin
         if (in_col_ff == cfg.w_m1) begin
            in_col_in = '0;
            in_row_in = (in_row_ff == cfg.h_m1) ? '0 : in_row_ff + 1'b1;
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
         fill_in = emit ? cfg.w + 1'b1 : fill_ff + 1'b1;
         if (emit) begin
            if (emit_col_ff == cfg.w_m1) begin
               emit_col_in = '0;
               emit_row_in = (emit_row_ff == cfg.h_m1) ? '0 : emit_row_ff + 1'b1;
            end else begin
               emit_col_in = emit_col_ff + 1'b1;
            end
            done_in = last ? '0 : done_ff + 1'b1;
            // a drain that ends the frame restarts the stream
            if (drain && last) begin
               in_col_in   = '0;
               in_row_in   = '0;
               emit_col_in = '0;
               emit_row_in = '0;
               fill_in     = '0;
               done_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         emit_col_ff <= '0;
         emit_row_ff <= '0;
         fill_ff     <= '0;
         done_ff     <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         emit_col_ff <= emit_col_in;
         emit_row_ff <= emit_row_in;
         fill_ff     <= fill_in;
         done_ff     <= done_in;
      end
   end

endmodule

@@ design/bm3_queue.sv @@
module bm3_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bm3_pkg::fe_item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output bm3_pkg::fe_item_type head,
   output logic                 empty
);
   import bm3_pkg::*;

   fe_item_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ design/bm3_back.sv @@
module bm3_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bm3_pkg::cfg_type            cfg,
   input  bm3_pkg::fe_item_type        q_head,
   input  logic                        q_empty,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output bm3_pkg::out_item_type       rsp_item,
   output bm3_pkg::bk_status_type      status
);
   import bm3_pkg::*;

   fe_item_type          a_item_ff;
   logic                 a_valid_ff;
   logic                 fwd_ff;
   logic [PIX_W-1:0]     fwd_a_ff, fwd_b_ff;
   logic [PIX_W-1:0]     ram_a_q, ram_b_q, eff_a, eff_b;
   logic [PIX_W-1:0]     win_ff [9];
   logic [PIX_W-1:0]     win_in [9];
   logic [PIX_W-1:0]     target, centre, value;
   logic [8:0]           use_cell;
   logic                 hit, out_push, out_pop, fwd_in;
   out_item_type         out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] owr_ff, ord_ff;
   logic [OUT_CNT_W-1:0] ocount_ff, ocount_in;

   // take an item only if its result is sure to find room
   assign q_pop = !q_empty &&
                  ((ocount_ff + OUT_CNT_W'(a_valid_ff)) < OUT_CNT_W'(OUT_DEPTH));

   // same column back to back: forward what the stage is writing
   assign fwd_in = q_pop && a_valid_ff && (a_item_ff.col == q_head.col);
   assign eff_a  = fwd_ff ? fwd_a_ff : ram_a_q;
   assign eff_b  = fwd_ff ? fwd_b_ff : ram_b_q;

   // line stores: a holds the previous line, b the one before
   bm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock (clock),
      .we    (a_valid_ff),
      .waddr (a_item_ff.col),
      .wdata (a_item_ff.pix),
      .raddr (q_head.col),
      .rdata (ram_a_q)
   );

   bm3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock (clock),
      .we    (a_valid_ff),
      .waddr (a_item_ff.col),
      .wdata (eff_a),
      .raddr (q_head.col),
      .rdata (ram_b_q)
   );

   // window shift
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3+1];
         win_in[r*3 + 1] = win_ff[r*3+2];
      end
      win_in[2] = eff_b;
      win_in[5] = eff_a;
      win_in[8] = a_item_ff.pix;
   end

   // neighbours that count: inside the image, corners only when 8-connected
   always_comb begin
      use_cell[0] = cfg.eight && !a_item_ff.at_top && !a_item_ff.at_left;
      use_cell[1] = !a_item_ff.at_top;
      use_cell[2] = cfg.eight && !a_item_ff.at_top && !a_item_ff.at_right;
      use_cell[3] = !a_item_ff.at_left;
      use_cell[4] = 1'b1;
      use_cell[5] = !a_item_ff.at_right;
      use_cell[6] = cfg.eight && !a_item_ff.at_bottom && !a_item_ff.at_left;
      use_cell[7] = !a_item_ff.at_bottom;
      use_cell[8] = cfg.eight && !a_item_ff.at_bottom && !a_item_ff.at_right;
   end

   assign target = cfg.erode ? cfg.white : cfg.black;
   assign centre = win_in[4];

   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < 9; i++) begin
         hit = hit | (use_cell[i] && (win_in[i] == target));
      end
      if (cfg.erode) begin
         value = (centre == cfg.black && hit) ? cfg.white : centre;
      end else begin
         value = hit ? cfg.black : centre;
      end
   end

   // result queue
   assign out_push  = a_valid_ff && a_item_ff.emit;
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_empty = (ocount_ff == '0);
   assign rsp_item  = out_mem_ff[ord_ff];
   assign ocount_in = ocount_ff + OUT_CNT_W'(out_push) - OUT_CNT_W'(out_pop);

   assign status.out_count = ocount_ff;
   assign status.a_valid   = a_valid_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_item_ff <= q_head;
      end
      fwd_a_ff <= a_item_ff.pix;
      fwd_b_ff <= eff_a;
      if (a_valid_ff) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
      if (out_push) begin
         out_mem_ff[owr_ff] <= '{pixel: value, col: a_item_ff.ecol,
                                 row: a_item_ff.erow, last: a_item_ff.last};
      end
      if (reset) begin
         a_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
         owr_ff     <= '0;
         ord_ff     <= '0;
         ocount_ff  <= '0;
      end else begin
         a_valid_ff <= q_pop;
         fwd_ff     <= fwd_in;
         owr_ff     <= out_push ? owr_ff + 1'b1 : owr_ff;
         ord_ff     <= out_pop ? ord_ff + 1'b1 : ord_ff;
         ocount_ff  <= ocount_in;
      end
   end

endmodule

@@ design/binary_morphology_3x3.sv @@
// Channel  Ports                                         Handshake
// input    req_command, req_pixel_in                     req_push, req_full
// result   rsp_pixel_out, rsp_out_col, rsp_out_row,      rsp_pop, rsp_empty
//          rsp_frame_last
// config   csr_index, csr_wdata                          csr_we
//
// One item per cycle while neither side stalls; a taken item passes the item
// queue, the back stage and the result queue before its result shows on rsp_*.
// The line stores have one write and one read port each; a column repeated
// on consecutive items is forwarded around the memory.
// Reset is synchronous and clears control only; line stores are not cleared.
// Either side may stall freely: a 4-entry queue sits between front and back
// and a 4-entry result queue holds finished items.
module binary_morphology_3x3 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_command,
   input  logic [bm3_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [bm3_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic [bm3_pkg::COL_W-1:0]       rsp_out_col,
   output logic [bm3_pkg::ROW_W-1:0]       rsp_out_row,
   output logic                            rsp_frame_last,
   input  logic                            csr_we,
   input  logic [bm3_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bm3_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bm3_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff, w_eff, h_eff;
   logic              erode_ff, eight_ff;
   logic [PIX_W-1:0]  black_ff, white_ff;
   logic [AREA_W-1:0] area_ff;
   logic              size_clear;
   cfg_type           cfg;
   fe_item_type       q_in_item, q_head;
   logic              q_push, q_full, q_pop, q_empty;
   out_item_type      rsp_item;
   bk_status_type     bk_status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
         erode_ff  <= 1'b0;
         eight_ff  <= 1'b1;
         black_ff  <= '0;
         white_ff  <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:     width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT:    height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_ERODE_MODE:      erode_ff  <= csr_wdata[0];
            CSR_EIGHT_CONNECTED: eight_ff  <= csr_wdata[0];
            CSR_BLACK_LEVEL:     black_ff  <= csr_wdata[PIX_W-1:0];
            CSR_WHITE_LEVEL:     white_ff  <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   assign size_clear = csr_we &&
                       (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   // clamp sizes to 1..max
   assign w_eff = (width_ff == '0) ? SIZE_W'(1) :
                  (width_ff > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? SIZE_W'(1) :
                  (height_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_ff;

   // frame area, registered
   always_ff @(posedge clock) begin
      area_ff <= AREA_W'(w_eff) * AREA_W'(h_eff);
   end

   always_comb begin
      cfg.w     = w_eff;
      cfg.w_m1  = COL_W'(w_eff - 1'b1);
      cfg.h_m1  = ROW_W'(h_eff - 1'b1);
      cfg.erode = erode_ff;
      cfg.eight = eight_ff;
      cfg.black = black_ff;
      cfg.white = white_ff;
   end

   bm3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .clear        (size_clear),
      .cfg          (cfg),
      .wh           (area_ff),
      .req_push     (req_push),
      .req_command  (req_command),
      .req_pixel_in (req_pixel_in),
      .req_full     (req_full),
      .q_push       (q_push),
      .q_item       (q_in_item),
      .q_full       (q_full)
   );

   bm3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   bm3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .status    (bk_status)
   );

   assign rsp_pixel_out  = rsp_item.pixel;
   assign rsp_out_col    = rsp_item.col;
   assign rsp_out_row    = rsp_item.row;
   assign rsp_frame_last = rsp_item.last;

   // results in flight never exceed the result queue
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (OUT_CNT_W'(bk_status.out_count) + OUT_CNT_W'(bk_status.a_valid))
         <= OUT_CNT_W'(OUT_DEPTH))
      else $error("result queue overcommitted");

   // nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full && !bk_status.a_valid)
      else $error("state not cleared by reset");

   // back end only moves items it was given
   a_stage_src: assert property (@(posedge clock) disable iff (reset)
      bk_status.a_valid |-> $past(!q_empty))
      else $error("back stage loaded from empty queue");

endmodule
